### rtl/pvog_pkg.sv
package pvog_pkg;

  localparam int MAX_CELLS = 32;
  localparam int VOX_W     = $clog2(MAX_CELLS);
  localparam int N_W       = VOX_W + 1;
  localparam int ROWS      = MAX_CELLS * MAX_CELLS;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int CUR_W     = 3 * VOX_W + 1;
  localparam int NN_W      = 2 * N_W;
  localparam int CELL_W    = 31;
  localparam int COORD_W   = 32;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_MIN_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_CELL_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_CELL_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_CELL_Z = 3'd5;
  localparam logic [IDX_W-1:0] REG_CELLS  = 3'd6;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_NEXT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_QGO, ST_QWAIT, ST_ARD, ST_AWR, ST_CMUL, ST_CADD,
    ST_NMUL1, ST_NMUL2, ST_NDZ, ST_NDY, ST_NRD, ST_NCHK, ST_OUT
  } state_t;

  typedef struct packed {
    logic       done;
    logic       sat;
    logic [5:0] q;
  } quant_res_t;

endpackage

### rtl/pvog_ram.sv
module pvog_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/pvog_quant.sv
module pvog_quant
  import pvog_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [COORD_W:0]  dividend,
  input  logic [CELL_W-1:0]        divisor,
  output quant_res_t               res
);

  logic              busy_r;
  logic              done_r;
  logic              sat_r;
  logic [2:0]        k_r;
  logic [COORD_W-1:0] rem_r;
  logic [CELL_W-1:0] div_r;
  logic [5:0]        q_r;
  logic [CELL_W+5:0] trial;
  logic              ge;

  // one quotient bit per cycle; the top trial (bit 6) only flags saturation
  assign trial = (CELL_W + 6)'(div_r) << k_r;
  assign ge    = (CELL_W + 6)'(rem_r) >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
      k_r    <= 3'd0;
      q_r    <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= 6'd0;
        sat_r <= 1'b0;
        if (!dividend[COORD_W] && (dividend != '0)) begin
          busy_r <= 1'b1;
          k_r    <= 3'd6;
          rem_r  <= dividend[COORD_W-1:0];
          div_r  <= divisor;
        end else begin
          done_r <= 1'b1;
        end
      end else if (busy_r) begin
        k_r <= k_r - 3'd1;
        if (ge && (k_r == 3'd6)) begin
          sat_r  <= 1'b1;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          if (ge) begin
            rem_r <= rem_r - trial[COORD_W-1:0];
            q_r   <= q_r | (6'd1 << k_r);
          end
          if (k_r == 3'd0) begin
            done_r <= 1'b1;
            busy_r <= 1'b0;
          end
        end
      end
    end
  end

  assign res = '{done: done_r, sat: sat_r, q: q_r};

endmodule

### rtl/pvog_corner.sv
module pvog_corner
  import pvog_pkg::*;
(
  input  logic                      clk,
  input  logic                      load,
  input  logic [VOX_W-1:0]          idx,
  input  logic [CELL_W-1:0]         csize,
  input  logic signed [COORD_W-1:0] base,
  output logic signed [COORD_W-1:0] lo,
  output logic signed [COORD_W-1:0] hi
);

  localparam int P_W = CELL_W + N_W;

  logic [P_W-1:0]            prod_lo_r;
  logic [P_W-1:0]            prod_hi_r;
  logic signed [COORD_W-1:0] base_r;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [P_W+1:0] v);
    logic signed [P_W+1:0] vmax;
    logic signed [P_W+1:0] vmin;
    vmax = (P_W + 2)'(32'sh7FFF_FFFF);
    vmin = -(P_W + 2)'(34'sh0_8000_0000);
    if (v > vmax) begin
      return 32'sh7FFF_FFFF;
    end else if (v < vmin) begin
      return 32'sh8000_0000;
    end
    return v[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (load) begin
      prod_lo_r <= P_W'(idx) * P_W'(csize);
      prod_hi_r <= (P_W'(idx) + P_W'(1)) * P_W'(csize);
      base_r    <= base;
    end
  end

  assign lo = sat32((P_W + 2)'(base_r) + $signed({2'b00, prod_lo_r}));
  assign hi = sat32((P_W + 2)'(base_r) + $signed({2'b00, prod_hi_r}));

endmodule

### rtl/point_voxel_occupancy_grid_top.sv
// Add: three quantizer runs (one per axis), a read-modify-write of one bitmap row,
// then corner math for each axis.
// Clear sweeps all 1024 bitmap rows.
// Next splits the cursor and scans rows to a set bit or the grid end; a hit gets corners.
// Throughput: one item at a time; the result register lets the next item enter.
// Reset: synchronous active-low; a sweep over all 1024 rows then zeroes the bitmap, no item taken.
module point_voxel_occupancy_grid_top
  import pvog_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [95:0]    in_tdata,   // point_x, point_y, point_z
  input  logic [1:0]     in_tuser,   // command
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [207:0]   out_tdata,  // voxel_x/y/z, low_corner_x/y/z, high_corner_x/y/z, pad
  output logic [1:0]     out_tuser,  // newly_set, scan_done
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]    cfg_data
);

  state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] min_r [3];
  logic [CELL_W-1:0]         cell_r [3];
  logic [CELL_W-1:0]         cell_eff [3];
  logic [N_W-1:0]            cells_r;
  logic [N_W-1:0]            n;

  logic signed [COORD_W-1:0] pt_r [3];
  logic [1:0]                ax_r;
  logic [VOX_W-1:0]          idx_r [3];
  logic [ROW_AW-1:0]         row_r;
  logic                      clr_reply_r;
  logic [NN_W-1:0]           nn_r;
  logic [CUR_W-1:0]          tot_r;
  logic [CUR_W-1:0]          rem_r;
  logic [CUR_W-1:0]          lin_r;
  logic [CUR_W-1:0]          cursor_r;
  logic [VOX_W-1:0]          xc_r, yc_r, zc_r;

  logic [VOX_W-1:0]          res_vox_r [3];
  logic signed [COORD_W-1:0] res_lo_r [3];
  logic signed [COORD_W-1:0] res_hi_r [3];
  logic                      res_new_r, res_done_r;

  logic                      out_tvalid_r;
  logic [207:0]              out_tdata_r;
  logic [1:0]                out_tuser_r;

  logic                      in_acc;
  logic                      q_start, c_load, ram_we, out_load;
  quant_res_t                qres;
  logic signed [COORD_W:0]   q_dividend;
  logic [N_W-1:0]            q_clamped;
  logic signed [COORD_W-1:0] c_lo, c_hi;

  logic [ROW_AW-1:0]         ram_addr;
  logic [MAX_CELLS-1:0]      ram_wdata, ram_rdata;
  logic [MAX_CELLS-1:0]      cand;
  logic                      found;
  logic [VOX_W-1:0]          fx;
  logic                      last_y, last_row;

  assign cfg_ready = 1'b1;
  assign n = (cells_r == '0) ? N_W'(1) :
             (cells_r > N_W'(MAX_CELLS)) ? N_W'(MAX_CELLS) : cells_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cell_eff[a] = (cell_r[a] == '0) ? CELL_W'(1) : cell_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        min_r[a]  <= '0;
        cell_r[a] <= CELL_W'(65536);
      end
      cells_r <= N_W'(MAX_CELLS);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_X:  min_r[0]  <= cfg_data;
        REG_MIN_Y:  min_r[1]  <= cfg_data;
        REG_MIN_Z:  min_r[2]  <= cfg_data;
        REG_CELL_X: cell_r[0] <= cfg_data[CELL_W-1:0];
        REG_CELL_Y: cell_r[1] <= cfg_data[CELL_W-1:0];
        REG_CELL_Z: cell_r[2] <= cfg_data[CELL_W-1:0];
        REG_CELLS:  cells_r   <= cfg_data[N_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc = in_tvalid && in_tready;

  // scan helpers
  assign cand = ram_rdata & ({MAX_CELLS{1'b1}} << xc_r) & ~({MAX_CELLS{1'b1}} << n);
  assign found = |cand;
  always_comb begin
    fx = '0;
    for (int i = MAX_CELLS - 1; i >= 0; i--) begin
      if (cand[i]) fx = VOX_W'(i);
    end
  end
  assign last_y   = (N_W'(yc_r) + N_W'(1)) == n;
  assign last_row = last_y && ((N_W'(zc_r) + N_W'(1)) == n);

  assign q_dividend = (COORD_W + 1)'(pt_r[ax_r]) - (COORD_W + 1)'(min_r[ax_r]);
  assign q_clamped  = (qres.sat || (qres.q >= n)) ? (n - N_W'(1)) : qres.q;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:   if (row_r == ROW_AW'(ROWS - 1)) state_nxt = clr_reply_r ? ST_OUT : ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd_t'(in_tuser))
            CMD_CLEAR: state_nxt = ST_CLR;
            CMD_ADD:   state_nxt = ST_QGO;
            CMD_NEXT:  state_nxt = ST_NMUL1;
            default:   state_nxt = ST_OUT;
          endcase
        end
      end
      ST_QGO:   state_nxt = ST_QWAIT;
      ST_QWAIT: if (qres.done) state_nxt = (ax_r == 2'd2) ? ST_ARD : ST_QGO;
      ST_ARD:   state_nxt = ST_AWR;
      ST_AWR:   state_nxt = ST_CMUL;
      ST_CMUL:  state_nxt = ST_CADD;
      ST_CADD:  state_nxt = (ax_r == 2'd2) ? ST_OUT : ST_CMUL;
      ST_NMUL1: state_nxt = ST_NMUL2;
      ST_NMUL2: state_nxt = ST_NDZ;
      ST_NDZ: begin
        if (cursor_r >= tot_r) state_nxt = ST_OUT;
        else if (rem_r < CUR_W'(nn_r)) state_nxt = ST_NDY;
      end
      ST_NDY:   if (rem_r < CUR_W'(n)) state_nxt = ST_NRD;
      ST_NRD:   state_nxt = ST_NCHK;
      ST_NCHK: begin
        if (found) state_nxt = ST_CMUL;
        else if (last_row) state_nxt = ST_OUT;
        else state_nxt = ST_NRD;
      end
      ST_OUT:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    q_start   = 1'b0;
    c_load    = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    ram_addr  = {zc_r, yc_r};
    ram_wdata = ram_rdata | (MAX_CELLS'(1) << idx_r[0]);
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_QGO:  q_start = 1'b1;
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = row_r;
        ram_wdata = '0;
      end
      ST_ARD:  ram_addr = {idx_r[2], idx_r[1]};
      ST_AWR: begin
        ram_we   = 1'b1;
        ram_addr = {idx_r[2], idx_r[1]};
      end
      ST_CMUL: c_load = 1'b1;
      ST_OUT:  out_load = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      row_r       <= '0;
      clr_reply_r <= 1'b0;
      cursor_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) row_r <= row_r + ROW_AW'(1);
      if (in_acc) begin
        clr_reply_r <= cmd_t'(in_tuser) == CMD_CLEAR;
        if (cmd_t'(in_tuser) == CMD_CLEAR) cursor_r <= '0;
      end
      if (state_r == ST_NCHK) begin
        if (found) cursor_r <= lin_r + CUR_W'(fx) + CUR_W'(1);
        else if (last_row) cursor_r <= tot_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pt_r[0] <= in_tdata[31:0];
      pt_r[1] <= in_tdata[63:32];
      pt_r[2] <= in_tdata[95:64];
      ax_r    <= 2'd0;
      for (int a = 0; a < 3; a++) begin
        res_vox_r[a] <= '0;
        res_lo_r[a]  <= '0;
        res_hi_r[a]  <= '0;
      end
      res_new_r  <= 1'b0;
      res_done_r <= 1'b0;
    end
    unique case (state_r)
      ST_QWAIT: begin
        if (qres.done) begin
          idx_r[ax_r] <= q_clamped[VOX_W-1:0];
          ax_r        <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
      end
      ST_AWR: res_new_r <= !ram_rdata[idx_r[0]];
      ST_CADD: begin
        res_lo_r[ax_r]  <= c_lo;
        res_hi_r[ax_r]  <= c_hi;
        res_vox_r[ax_r] <= idx_r[ax_r];
        ax_r            <= ax_r + 2'd1;
      end
      ST_NMUL1: nn_r <= NN_W'(n) * NN_W'(n);
      ST_NMUL2: begin
        tot_r <= CUR_W'(nn_r) * CUR_W'(n);
        rem_r <= cursor_r;
        zc_r  <= '0;
        yc_r  <= '0;
      end
      ST_NDZ: begin
        if (cursor_r >= tot_r) begin
          res_done_r <= 1'b1;
        end else if (rem_r >= CUR_W'(nn_r)) begin
          rem_r <= rem_r - CUR_W'(nn_r);
          zc_r  <= zc_r + VOX_W'(1);
        end
      end
      ST_NDY: begin
        if (rem_r >= CUR_W'(n)) begin
          rem_r <= rem_r - CUR_W'(n);
          yc_r  <= yc_r + VOX_W'(1);
        end else begin
          xc_r  <= rem_r[VOX_W-1:0];
          lin_r <= cursor_r - rem_r;
        end
      end
      ST_NCHK: begin
        if (found) begin
          idx_r[0]  <= fx;
          idx_r[1]  <= yc_r;
          idx_r[2]  <= zc_r;
          res_new_r <= 1'b1;
          ax_r      <= 2'd0;
        end else if (last_row) begin
          res_done_r <= 1'b1;
        end else begin
          // step to the start of the next row
          xc_r  <= '0;
          lin_r <= lin_r + CUR_W'(n);
          if (last_y) begin
            yc_r <= '0;
            zc_r <= zc_r + VOX_W'(1);
          end else begin
            yc_r <= yc_r + VOX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  pvog_quant u_quant (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (q_start),
    .dividend (q_dividend),
    .divisor  (cell_eff[ax_r]),
    .res      (qres)
  );

  pvog_corner u_corner (
    .clk   (clk),
    .load  (c_load),
    .idx   (idx_r[ax_r]),
    .csize (cell_eff[ax_r]),
    .base  (min_r[ax_r]),
    .lo    (c_lo),
    .hi    (c_hi)
  );

  pvog_ram #(
    .WIDTH (MAX_CELLS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {1'b0, res_hi_r[2], res_hi_r[1], res_hi_r[0],
                      res_lo_r[2], res_lo_r[1], res_lo_r[0],
                      res_vox_r[2], res_vox_r[1], res_vox_r[0]};
      out_tuser_r <= {res_done_r, res_new_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  a_ram_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLR || state_r == ST_AWR))
    else $error("bitmap written outside clear sweep or add update");

  a_found_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(res_new_r && res_done_r))
    else $error("result flags both newly set and scan done");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_W'(ROWS * MAX_CELLS))
    else $error("scan cursor past the grid");

  a_quant_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QWAIT && qres.done) |-> (q_clamped < n))
    else $error("quantized index not below cell count");
`endif

endmodule

### tb/sv/point_voxel_occupancy_grid_top_test.sv
`timescale 1ns / 100ps

module point_voxel_occupancy_grid_top_test;
  import pvog_pkg::*;

  logic           clk;
  logic           rst_n;
  logic           in_tvalid;
  logic           in_tready;
  logic [95:0]    in_tdata;   // point_x, point_y, point_z
  logic [1:0]     in_tuser;   // command
  logic           out_tvalid;
  logic           out_tready;
  logic [207:0]   out_tdata;  // voxel_x/y/z, low_corner_x/y/z, high_corner_x/y/z, pad
  logic [1:0]     out_tuser;  // newly_set, scan_done
  logic           cfg_valid;
  logic           cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [31:0]    cfg_data;

  point_voxel_occupancy_grid_top dut (.*);

  typedef struct {
    logic [207:0] data;
    logic [1:0]   user;
  } voxel_result_t;

  class grid_scoreboard;
    bit            occ[MAX_CELLS*MAX_CELLS*MAX_CELLS];
    int unsigned   cursor;
    longint        gmin[3];
    longint        csz[3];
    int unsigned   cells;
    voxel_result_t pending_q[$];
    int            mismatches;

    function new();
      for (int a = 0; a < 3; a++) begin
        gmin[a] = 0;
        csz[a] = 65536;
      end
      cells = 32;
      foreach (occ[i]) occ[i] = 0;
      cursor = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_MIN_X, REG_MIN_Y, REG_MIN_Z: gmin[idx] = longint'($signed(v));
        REG_CELL_X, REG_CELL_Y, REG_CELL_Z: csz[idx-REG_CELL_X] = longint'(v[30:0]);
        REG_CELLS: cells = v[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_n();
      if (cells < 1) return 1;
      if (cells > MAX_CELLS) return MAX_CELLS;
      return cells;
    endfunction

    function longint cell_of(int a);
      return (csz[a] == 0) ? 1 : csz[a];
    endfunction

    function logic [31:0] sat(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function logic [207:0] voxel_word(int unsigned ix, int unsigned iy, int unsigned iz);
      logic [207:0] w;
      longint       i;
      int unsigned  ids[3];
      w = '0;
      ids[0] = ix; ids[1] = iy; ids[2] = iz;
      for (int a = 0; a < 3; a++) begin
        i = longint'(ids[a]);
        w[5*a +: 5] = ids[a][4:0];
        w[15 + 32*a +: 32] = sat(gmin[a] + i * cell_of(a));
        w[111 + 32*a +: 32] = sat(gmin[a] + (i + 1) * cell_of(a));
      end
      return w;
    endfunction

    function void note_input(logic [1:0] cmd, logic [95:0] pt);
      voxel_result_t r;
      int unsigned   n, total, c, addr;
      int unsigned   ids[3];
      longint        d, q;
      bit            found;
      r.data = '0;
      r.user = '0;
      n = eff_n();
      case (cmd_t'(cmd))
        CMD_CLEAR: begin
          foreach (occ[i]) occ[i] = 0;
          cursor = 0;
        end
        CMD_ADD: begin
          for (int a = 0; a < 3; a++) begin
            d = longint'($signed(pt[32*a +: 32])) - gmin[a];
            q = (d > 0) ? d / cell_of(a) : 0;
            if (q > n - 1) q = n - 1;
            ids[a] = 32'(q);
          end
          addr = ids[0] + MAX_CELLS * (ids[1] + MAX_CELLS * ids[2]);
          r.data = voxel_word(ids[0], ids[1], ids[2]);
          r.user[0] = !occ[addr];
          occ[addr] = 1;
        end
        CMD_NEXT: begin
          total = n * n * n;
          c = cursor;
          found = 0;
          while (c < total && !found) begin
            ids[0] = c % n;
            ids[1] = (c / n) % n;
            ids[2] = c / (n * n);
            c++;
            if (occ[ids[0] + MAX_CELLS * (ids[1] + MAX_CELLS * ids[2])]) found = 1;
          end
          if (found) begin
            cursor = c;
            r.data = voxel_word(ids[0], ids[1], ids[2]);
            r.user[0] = 1;
          end else begin
            if (cursor < total) cursor = total;
            r.user[1] = 1;
          end
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check(logic [207:0] d, logic [1:0] u);
      voxel_result_t e;
      string         names[11];
      int            off, w;
      logic [31:0]   ev, av;
      names = '{"voxel_x", "voxel_y", "voxel_z", "low_corner_x", "low_corner_y",
                "low_corner_z", "high_corner_x", "high_corner_y", "high_corner_z",
                "newly_set", "scan_done"};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: data %h user %b", d, u);
        return;
      end
      e = pending_q.pop_front();
      for (int f = 0; f < 11; f++) begin
        if (f < 3) begin
          off = 5 * f; w = 5;
        end else begin
          off = 15 + 32 * (f - 3); w = 32;
        end
        if (f < 9) begin
          ev = 32'((e.data >> off) & ((64'd1 << w) - 1));
          av = 32'((d >> off) & ((64'd1 << w) - 1));
        end else begin
          ev = 32'(e.user[f-9]);
          av = 32'(u[f-9]);
        end
        if (ev !== av) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", names[f], ev, av);
        end
      end
    endfunction
  endclass

  grid_scoreboard grid_sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  bit             hold_req;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready = 0;
        repeat (3000) @(negedge clk);
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) grid_sb.check(out_tdata, out_tuser);

  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser = cmd;
    in_tdata = {pz, py, px};
    do @(posedge clk); while (!in_tready);
    grid_sb.note_input(cmd, {pz, py, px});
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid = 0;
    while (grid_sb.pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] v);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    grid_sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic write_all(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] n);
    write_reg(REG_MIN_X, mx);
    write_reg(REG_MIN_Y, my);
    write_reg(REG_MIN_Z, mz);
    write_reg(REG_CELL_X, cx);
    write_reg(REG_CELL_Y, cy);
    write_reg(REG_CELL_Z, cz);
    write_reg(REG_CELLS, n);
  endtask

  // aim mostly inside or just past the grid so adds land on a spread of voxels
  function automatic logic [31:0] pick_coord(int a);
    longint c, i;
    c = grid_sb.cell_of(a);
    if ($urandom_range(9) < 2) return $urandom;
    i = $urandom_range(grid_sb.eff_n() + 1);
    if ($urandom_range(19) == 0) i = -1;
    return 32'(grid_sb.gmin[a] + i * c + ($urandom % c));
  endfunction

  task automatic run_phase(int count, int next_pct);
    int unsigned r;
    send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 2) send_item(CMD_NONE, $urandom, $urandom, $urandom);
      else if (r < 4) send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
      else if (r < 4 + next_pct) send_item(CMD_NEXT, $urandom, $urandom, $urandom);
      else send_item(CMD_ADD, pick_coord(0), pick_coord(1), pick_coord(2));
    end
    wait_idle();
  endtask

  initial begin
    grid_sb = new();
    hold_req = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = CMD_CLEAR;
    cfg_valid = 0;
    cfg_index = REG_MIN_X;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n = 1;

    // directed: extremes, repeats, scan to the end, unused command
    send_item(CMD_ADD, 32'h0, 32'h0, 32'h0);
    send_item(CMD_ADD, 32'h0, 32'h0, 32'h0);
    send_item(CMD_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_item(CMD_ADD, 32'h80000000, 32'h80000000, 32'h80000000);
    send_item(CMD_ADD, 32'h00018000, 32'h80000000, 32'h001f0000);
    send_item(CMD_NEXT, 32'h0, 32'h0, 32'h0);
    send_item(CMD_NEXT, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_item(CMD_NEXT, 32'h0, 32'h0, 32'h0);
    send_item(CMD_NEXT, 32'h0, 32'h0, 32'h0);
    send_item(CMD_NEXT, 32'h0, 32'h0, 32'h0);
    send_item(CMD_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_item(CMD_ADD, 32'h00050000, 32'h00020000, 32'h00010000);
    send_item(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
    send_item(CMD_NEXT, 32'h0, 32'h0, 32'h0);
    send_item(CMD_ADD, 32'hffff0000, 32'h00200000, 32'h0001ffff);
    send_item(CMD_NEXT, 32'h0, 32'h0, 32'h0);
    wait_idle();

    // cells shrink mid-scan: cursor kept as a linear position
    write_reg(REG_CELLS, 32'd2);
    send_item(CMD_NEXT, 32'h0, 32'h0, 32'h0);
    send_item(CMD_NEXT, 32'h0, 32'h0, 32'h0);
    wait_idle();

    write_all(32'h0, 32'h0, 32'h0, 32'h00010000, 32'h00010000, 32'h00010000, 32'd32);
    run_phase(200, 6);

    send_idle_pct = 46;
    write_all(-32'sd229376, 32'h00001000, -32'sd1, 32'h00008000, 32'h00030000,
              32'h00000100, 32'd4);
    run_phase(200, 20);

    send_idle_pct = 0;
    recv_idle_pct = 46;
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd1);
    run_phase(200, 20);

    send_idle_pct = 22;
    recv_idle_pct = 22;
    write_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'd0);
    run_phase(200, 20);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h1, 32'h1, 32'd63);
    run_phase(150, 6);

    send_idle_pct = 46;
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(63));
    run_phase(200, 10);

    // zero cell size, with a long receiver hold-off while items keep coming
    send_idle_pct = 22;
    recv_idle_pct = 22;
    write_all($urandom, $urandom, $urandom, 32'h80000000, 32'h0, 32'h00000003, 32'd8);
    hold_req = 1;
    run_phase(200, 15);

    send_idle_pct = 0;
    recv_idle_pct = 46;
    write_all($urandom, $urandom, $urandom, $urandom_range(65536, 1),
              $urandom_range(65536, 1), $urandom_range(65536, 1), $urandom_range(16, 1));
    run_phase(100, 20);

    in_tvalid = 0;
    while (grid_sb.pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (grid_sb.mismatches == 0 && grid_sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
